@@ src/fdr_pkg.sv @@
`default_nettype none

package fdr_pkg;

    localparam int DEF_MAX_WIDTH  = 512;
    localparam int DEF_MAX_HEIGHT = 512;
    localparam int DEF_MAX_RUN    = 64;

    localparam int TOKEN_W   = 16;
    localparam int PIX_W     = 16;
    localparam int COORD_W   = 9;
    localparam int DIM_W     = 10;
    localparam int RUNLEN_W  = 7;
    localparam int START_W   = 11;
    localparam int MASK_W    = 64;
    localparam int OFF_W     = 6;
    localparam int WORDCNT_W = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 10;

    localparam int RST_FRAME_WIDTH  = 320;
    localparam int RST_FRAME_HEIGHT = 240;
    localparam int RST_RUN_LENGTH   = 16;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RUN_LENGTH   = 2'd2;

    typedef enum logic [1:0] {
        PH_LINE  = 2'd0,
        PH_RUN   = 2'd1,
        PH_MASK  = 2'd2,
        PH_PIXEL = 2'd3
    } phase_t;

    typedef struct packed {
        logic [DIM_W-1:0] idx;
        logic             wrap;
    } line_step_t;

    // Clamp a register value to 1..hi.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int hi);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
            r = DIM_W'(1);
        else if (int'(v) > hi)
            r = DIM_W'(hi);
        return r;
    endfunction

    // Advance the line counter; wraps at the frame height.
    function automatic line_step_t line_step(input logic [DIM_W-1:0] li,
                                             input logic [DIM_W-1:0] height);
        line_step_t       r;
        logic [DIM_W:0]   inc;
        inc = {1'b0, li} + (DIM_W+1)'(1);
        if (inc >= {1'b0, height})
        begin
            r.idx  = '0;
            r.wrap = 1'b1;
        end
        else
        begin
            r.idx  = inc[DIM_W-1:0];
            r.wrap = 1'b0;
        end
        return r;
    endfunction

    // Position of the first set bit counted from the MSB.
    function automatic logic [OFF_W-1:0] first_set(input logic [MASK_W-1:0] m);
        logic [OFF_W-1:0] pos;
        pos = '0;
        for (int i = MASK_W - 1; i >= 0; i--)
        begin
            if (m[MASK_W-1-i])
                pos = OFF_W'(i);
        end
        return pos;
    endfunction

endpackage

`default_nettype wire

@@ src/fdr_ram.sv @@
`default_nettype none

module fdr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

@@ src/frame_delta_run_decoder_top.sv @@
`default_nettype none

// Frame delta run decoder.
// token channel (token_valid/token_ready/token_value): one stream token per
//   transfer - line flag, run flag, mask word or pixel, by the parse position.
// result channel (result_valid/result_ready + fields): one transfer per written
//   pixel and per frame end; a frame end may share a transfer with a pixel.
// cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): frame width, frame
//   height and run length; always ready, write only while the decoder is idle.
// Throughput: one token per cycle when not stalled. Parser state sits in flops
//   and the token step (leading-one search over the run mask, run/line closing)
//   is combinational; changed pixels go to the frame store RAM write port.
// A result shows on the result port the cycle after its token transfer.
// Stall: the result register holds while result_ready is low and token_ready
//   drops with it; token_ready = !result_valid | result_ready.
// Reset: width 320, height 240, run length 16 (clamped to the maximums),
//   parser waits for a line flag at line 0. The frame store is not cleared;
//   it holds whatever was last written.

module frame_delta_run_decoder_top #(
    parameter int MAX_WIDTH  = fdr_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = fdr_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_RUN    = fdr_pkg::DEF_MAX_RUN
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    input  wire logic                           token_valid,
    output logic                                token_ready,
    input  wire logic [fdr_pkg::TOKEN_W-1:0]    token_value,

    output logic                                result_valid,
    input  wire logic                           result_ready,
    output logic                                write_valid,
    output logic      [fdr_pkg::COORD_W-1:0]    pixel_x,
    output logic      [fdr_pkg::COORD_W-1:0]    pixel_y,
    output logic      [fdr_pkg::PIX_W-1:0]      pixel_value,
    output logic                                frame_done,

    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [fdr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [fdr_pkg::CFG_DAT_W-1:0]  cfg_data
);

    import fdr_pkg::*;

    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW          = $clog2(STORE_DEPTH);
    localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_WIDTH);

    // configuration, kept clamped
    logic [DIM_W-1:0]     width_reg, height_reg;
    logic [RUNLEN_W-1:0]  runlen_reg;

    // parser state
    phase_t                 phase_reg, phase_next;
    logic [DIM_W-1:0]       line_index_reg, line_index_next;
    logic [START_W-1:0]     run_start_reg, run_start_next;
    logic [MASK_W-1:0]      run_mask_reg, run_mask_next;
    logic [WORDCNT_W-1:0]   words_seen_reg, words_seen_next;
    logic [OFF_W-1:0]       pixel_offset_reg, pixel_offset_next;

    // result register
    logic                   res_valid_reg;
    logic                   res_write_reg;
    logic [COORD_W-1:0]     res_x_reg, res_y_reg;
    logic [PIX_W-1:0]       res_pix_reg;
    logic                   res_done_reg;

    logic                   token_xfer;
    phase_t                 phase_a;
    logic [DIM_W-1:0]       line_a;
    logic [START_W-1:0]     start_a;
    logic                   done_hit;

    logic                   wrote;
    logic [START_W-1:0]     px;
    logic                   in_store;
    logic                   store_we;
    logic [AW-1:0]          store_addr;

    assign token_ready = !res_valid_reg || result_ready;
    assign token_xfer  = token_valid && token_ready;
    assign cfg_ready   = 1'b1;

    // next state
    always_comb
    begin
        line_step_t           ls_pre, ls_line, ls_run;
        logic [DIM_W-1:0]     left;
        logic [RUNLEN_W-1:0]  rw;
        logic [RUNLEN_W-1:0]  rw_round;
        logic [WORDCNT_W-1:0] words;
        logic [WORDCNT_W-1:0] seen_inc;
        logic [START_W-1:0]   run_end;
        logic                 scan_req;
        logic                 close_run_req;

        phase_a  = phase_reg;
        line_a   = line_index_reg;
        start_a  = run_start_reg;
        done_hit = 1'b0;
        scan_req = 1'b0;
        close_run_req = 1'b0;

        // width shrunk under a line in progress: close it first
        ls_pre = line_step(line_index_reg, height_reg);
        if (phase_reg != PH_LINE && run_start_reg >= {1'b0, width_reg})
        begin
            line_a   = ls_pre.idx;
            done_hit = ls_pre.wrap;
            start_a  = '0;
            phase_a  = PH_LINE;
        end

        phase_next        = phase_a;
        line_index_next   = line_a;
        run_start_next    = start_a;
        run_mask_next     = run_mask_reg;
        words_seen_next   = words_seen_reg;
        pixel_offset_next = pixel_offset_reg;

        if (start_a < {1'b0, width_reg})
            left = width_reg - start_a[DIM_W-1:0];
        else
            left = DIM_W'(1);
        if ({{(DIM_W-RUNLEN_W){1'b0}}, runlen_reg} < left)
            rw = runlen_reg;
        else
            rw = left[RUNLEN_W-1:0];
        // rw is at most 64, so rw + 15 fits in RUNLEN_W bits
        rw_round = rw + RUNLEN_W'(15);
        words    = rw_round[RUNLEN_W-1:4];
        seen_inc = words_seen_reg + WORDCNT_W'(1);

        ls_line = line_step(line_a, height_reg);

        case (phase_a)
            PH_LINE:
            begin
                run_start_next = '0;
                if (token_value == '0)
                begin
                    line_index_next = ls_line.idx;
                    done_hit        = done_hit | ls_line.wrap;
                end
                else
                begin
                    phase_next = PH_RUN;
                end
            end
            PH_RUN:
            begin
                if (token_value == '0)
                begin
                    close_run_req = 1'b1;
                end
                else
                begin
                    run_mask_next   = '0;
                    words_seen_next = '0;
                    phase_next      = PH_MASK;
                end
            end
            PH_MASK:
            begin
                if (words_seen_reg < WORDCNT_W'(4))
                    run_mask_next = run_mask_reg | (MASK_W'(token_value)
                                    << (7'd48 - {1'b0, words_seen_reg[1:0], 4'b0000}));
                words_seen_next = seen_inc;
                if (seen_inc >= words)
                begin
                    if (int'(rw) < MASK_W)
                        run_mask_next = run_mask_next & ~({MASK_W{1'b1}} >> rw);
                    words_seen_next = '0;
                    scan_req        = 1'b1;
                end
            end
            PH_PIXEL:
            begin
                run_mask_next = run_mask_reg &
                                ~(MASK_W'(1) << (6'(MASK_W-1) - pixel_offset_reg));
                scan_req      = 1'b1;
            end
            default:
            begin
            end
        endcase

        // leading-one search, or close the run (mask spent or run flag clear)
        run_end = start_a + START_W'(runlen_reg);
        ls_run  = line_step(line_a, height_reg);
        if (scan_req && (run_mask_next != '0))
        begin
            pixel_offset_next = first_set(run_mask_next);
            phase_next        = PH_PIXEL;
        end
        else if (scan_req || close_run_req)
        begin
            if (run_end >= {1'b0, width_reg})
            begin
                line_index_next = ls_run.idx;
                done_hit        = done_hit | ls_run.wrap;
                run_start_next  = '0;
                phase_next      = PH_LINE;
            end
            else
            begin
                run_start_next = run_end;
                phase_next     = PH_RUN;
            end
        end
    end

    // outputs of the step
    always_comb
    begin
        wrote      = (phase_a == PH_PIXEL);
        px         = start_a + START_W'(pixel_offset_reg);
        in_store   = (int'(px) < MAX_WIDTH) && (int'(line_a) < MAX_HEIGHT);
        store_we   = token_xfer && wrote && in_store;
        store_addr = AW'(line_a) * ROW_STRIDE + AW'(px);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg        <= clamp_dim(DIM_W'(RST_FRAME_WIDTH), MAX_WIDTH);
            height_reg       <= clamp_dim(DIM_W'(RST_FRAME_HEIGHT), MAX_HEIGHT);
            runlen_reg       <= RUNLEN_W'(clamp_dim(DIM_W'(RST_RUN_LENGTH), MAX_RUN));
            phase_reg        <= PH_LINE;
            line_index_reg   <= '0;
            run_start_reg    <= '0;
            run_mask_reg     <= '0;
            words_seen_reg   <= '0;
            pixel_offset_reg <= '0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_FRAME_WIDTH:  width_reg  <= clamp_dim(cfg_data, MAX_WIDTH);
                    REG_FRAME_HEIGHT: height_reg <= clamp_dim(cfg_data, MAX_HEIGHT);
                    REG_RUN_LENGTH:   runlen_reg <= RUNLEN_W'(clamp_dim(
                                          {3'b000, cfg_data[RUNLEN_W-1:0]}, MAX_RUN));
                    default:
                    begin
                    end
                endcase
            end
            if (token_xfer)
            begin
                phase_reg        <= phase_next;
                line_index_reg   <= line_index_next;
                run_start_reg    <= run_start_next;
                run_mask_reg     <= run_mask_next;
                words_seen_reg   <= words_seen_next;
                pixel_offset_reg <= pixel_offset_next;
                res_valid_reg    <= wrote || done_hit;
            end
            else if (result_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (token_xfer)
        begin
            res_write_reg <= wrote;
            res_x_reg     <= wrote ? px[COORD_W-1:0] : '0;
            res_y_reg     <= wrote ? line_a[COORD_W-1:0] : '0;
            res_pix_reg   <= wrote ? token_value : '0;
            res_done_reg  <= done_hit;
        end
    end

    assign result_valid = res_valid_reg;
    assign write_valid  = res_write_reg;
    assign pixel_x      = res_x_reg;
    assign pixel_y      = res_y_reg;
    assign pixel_value  = res_pix_reg;
    assign frame_done   = res_done_reg;

    fdr_ram #(
        .WIDTH (PIX_W),
        .DEPTH (STORE_DEPTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (store_we),
        .wr_addr (store_addr),
        .wr_data (token_value),
        .rd_en   (1'b0),
        .rd_addr (store_addr),
        .rd_data ()
    );

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        token_xfer |-> (!res_valid_reg || result_ready))
        else $error("result register overwritten while stalled");

    a_result_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (res_write_reg || res_done_reg))
        else $error("empty result transfer");

    a_pixel_selected: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PIXEL) |->
            run_mask_reg[6'(MASK_W-1) - pixel_offset_reg])
        else $error("pixel phase without selected mask bit");

    a_word_count: assert property (@(posedge clk) disable iff (!rst_n)
        token_xfer && (phase_a == PH_MASK) |=> (words_seen_reg <= WORDCNT_W'(4)))
        else $error("mask word count out of range");
`endif

endmodule

`default_nettype wire
